FILE: design/eamat_pkg.sv
// ----------------------------------------------------------------------------
// eamat_pkg: shared types and constants
// Angle reduction constants, CORDIC arctangent table and the stage payloads.
// ----------------------------------------------------------------------------
package eamat_pkg;

	localparam int AngleFracBits = 6;
	localparam int EntryFracBits = 14;
	localparam int QBits = 30;
	localparam int AngUnitBits = 24;
	localparam int CordicSteps = 30;
	localparam int CW = 34; // CORDIC x/y/z width
	localparam logic signed [CW-1:0] CordicGain = 34'sd652032874;

	localparam logic signed [17:0] FullTurn = 18'(360 * (1 << AngleFracBits));
	localparam logic signed [17:0] HalfTurn = 18'(180 * (1 << AngleFracBits));
	localparam logic signed [17:0] QuarterTurn = 18'(90 * (1 << AngleFracBits));

	typedef logic signed [15:0] angle_t;
	typedef logic signed [15:0] entry_t;
	typedef logic signed [CW-1:0] cw_t;

	typedef struct packed {
		cw_t x;
		cw_t y;
		cw_t z;
		logic flip;
	} cstage_t;

	typedef struct packed {
		entry_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
	} matrix_t;

	typedef struct packed {
		angle_t angle_x;
		angle_t angle_y;
		angle_t angle_z;
	} angles_t;

	function automatic cw_t atan_tab(input int i);
		cw_t t;
		case (i)
			0: t = 34'sd754974720;  1: t = 34'sd445687602;  2: t = 34'sd235489088;
			3: t = 34'sd119537938;  4: t = 34'sd60000934;   5: t = 34'sd30029717;
			6: t = 34'sd15018523;   7: t = 34'sd7509720;    8: t = 34'sd3754917;
			9: t = 34'sd1877466;    10: t = 34'sd938734;    11: t = 34'sd469367;
			12: t = 34'sd234684;    13: t = 34'sd117342;    14: t = 34'sd58671;
			15: t = 34'sd29335;     16: t = 34'sd14668;     17: t = 34'sd7334;
			18: t = 34'sd3667;      19: t = 34'sd1833;      20: t = 34'sd917;
			21: t = 34'sd458;       22: t = 34'sd229;       23: t = 34'sd115;
			24: t = 34'sd57;        25: t = 34'sd29;        26: t = 34'sd14;
			27: t = 34'sd7;         28: t = 34'sd4;         29: t = 34'sd2;
			default: t = '0;
		endcase
		return t;
	endfunction

	// Q2.30 product with round-half-up; operands in [-2^30, 2^30]
	function automatic cw_t qmul(input cw_t a, input cw_t b);
		logic signed [2*CW-1:0] p;
		p = 68'(a) * 68'(b) + (68'sd1 <<< (QBits - 1));
		return cw_t'(p >>> QBits);
	endfunction

	function automatic entry_t to_entry(input cw_t v);
		logic signed [CW:0] r;
		r = (35'(v) + (35'sd1 <<< (QBits - 1 - EntryFracBits))) >>> (QBits - EntryFracBits);
		if (r < -(35'sd1 <<< EntryFracBits)) r = -(35'sd1 <<< EntryFracBits);
		if (r > (35'sd1 <<< EntryFracBits)) r = 35'sd1 <<< EntryFracBits;
		return entry_t'(r);
	endfunction

endpackage

FILE: design/eamat_if.sv
// ----------------------------------------------------------------------------
// eamat_if: valid/ready channel
// Carries one item of a generic payload between a source and a sink.
// ----------------------------------------------------------------------------
interface eamat_if #(parameter type payload_t = logic) (input logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/eamat_sincos.sv
// ----------------------------------------------------------------------------
// eamat_sincos: pipelined CORDIC sine/cosine lane
// Reduces one angle to +/-90 degrees and runs 30 pipelined CORDIC stages.
// ----------------------------------------------------------------------------
module eamat_sincos import eamat_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  angle_t angle,
	output cw_t    sin_v,
	output cw_t    cos_v
);

	cstage_t st_s [CordicSteps+1];
	cstage_t red;
	logic signed [17:0] a;

	always_comb begin
		// the 16-bit range reaches less than one and a half turns either way: one step folds it
		a = 18'(angle);
		if (a > HalfTurn) a = a - FullTurn;
		else if (a <= -HalfTurn) a = a + FullTurn;
		red.flip = 1'b0;
		if (a > QuarterTurn) begin
			a = HalfTurn - a;
			red.flip = 1'b1;
		end else if (a < -QuarterTurn) begin
			a = -HalfTurn - a;
			red.flip = 1'b1;
		end
		red.z = cw_t'(a) <<< (AngUnitBits - AngleFracBits);
		red.x = CordicGain;
		red.y = '0;
	end

	always_ff @(posedge clk) begin
		if (en) st_s[0] <= red;
	end

	for (genvar i = 0; i < CordicSteps; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[i+1].flip <= st_s[i].flip;
				if (!st_s[i].z[CW-1]) begin
					st_s[i+1].x <= st_s[i].x - (st_s[i].y >>> i);
					st_s[i+1].y <= st_s[i].y + (st_s[i].x >>> i);
					st_s[i+1].z <= st_s[i].z - atan_tab(i);
				end else begin
					st_s[i+1].x <= st_s[i].x + (st_s[i].y >>> i);
					st_s[i+1].y <= st_s[i].y - (st_s[i].x >>> i);
					st_s[i+1].z <= st_s[i].z + atan_tab(i);
				end
			end
		end
	end

	cw_t xc, yc;
	localparam cw_t One = cw_t'(1) <<< QBits;
	always_comb begin
		xc = st_s[CordicSteps].x;
		yc = st_s[CordicSteps].y;
		if (xc > One) xc = One;
		if (xc < -One) xc = -One;
		if (yc > One) yc = One;
		if (yc < -One) yc = -One;
		cos_v = st_s[CordicSteps].flip ? -xc : xc;
		sin_v = yc;
	end

endmodule

FILE: design/eamat_merge.sv
// ----------------------------------------------------------------------------
// eamat_merge: matrix product stages
// Forms Rx*Ry*Rz from the three lanes' sine and cosine over three stages.
// ----------------------------------------------------------------------------
module eamat_merge import eamat_pkg::*; (
	input  logic    clk,
	input  logic    en,
	input  cw_t     sx, cx, sy, cy, sz, cz,
	output matrix_t mat
);

	cw_t sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	cw_t sycz_s2, sysz_s2, cycz_s2, cysz_s2, cxsz_s2, cxcz_s2, sxcy_s2, sxsz_s2, sxcz_s2,
		cxcy_s2, sx_s2, cx_s2, sy_s2;
	cw_t t10_s3, t11_s3, t20_s3, t21_s3;
	cw_t cycz_s3, cysz_s3, cxsz_s3, cxcz_s3, sxcy_s3, sxsz_s3, sxcz_s3, cxcy_s3, sy_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= sx; cx_s1 <= cx; sy_s1 <= sy;
			cy_s1 <= cy; sz_s1 <= sz; cz_s1 <= cz;
			sycz_s2 <= qmul(sy_s1, cz_s1);
			sysz_s2 <= qmul(sy_s1, sz_s1);
			cycz_s2 <= qmul(cy_s1, cz_s1);
			cysz_s2 <= qmul(cy_s1, sz_s1);
			cxsz_s2 <= qmul(cx_s1, sz_s1);
			cxcz_s2 <= qmul(cx_s1, cz_s1);
			sxcy_s2 <= qmul(sx_s1, cy_s1);
			sxsz_s2 <= qmul(sx_s1, sz_s1);
			sxcz_s2 <= qmul(sx_s1, cz_s1);
			cxcy_s2 <= qmul(cx_s1, cy_s1);
			sx_s2 <= sx_s1; cx_s2 <= cx_s1; sy_s2 <= sy_s1;
			t10_s3 <= qmul(sx_s2, sycz_s2);
			t11_s3 <= qmul(sx_s2, sysz_s2);
			t20_s3 <= qmul(cx_s2, sycz_s2);
			t21_s3 <= qmul(cx_s2, sysz_s2);
			cycz_s3 <= cycz_s2; cysz_s3 <= cysz_s2; cxsz_s3 <= cxsz_s2;
			cxcz_s3 <= cxcz_s2; sxcy_s3 <= sxcy_s2; sxsz_s3 <= sxsz_s2;
			sxcz_s3 <= sxcz_s2; cxcy_s3 <= cxcy_s2; sy_s3 <= sy_s2;
		end
	end

	always_comb begin
		mat.r00 = to_entry(cycz_s3);
		mat.r01 = to_entry(-cysz_s3);
		mat.r02 = to_entry(-sy_s3);
		mat.r10 = to_entry(cxsz_s3 - t10_s3);
		mat.r11 = to_entry(cxcz_s3 + t11_s3);
		mat.r12 = to_entry(-sxcy_s3);
		mat.r20 = to_entry(sxsz_s3 + t20_s3);
		mat.r21 = to_entry(sxcz_s3 - t21_s3);
		mat.r22 = to_entry(cxcy_s3);
	end

endmodule

FILE: design/euler_angles_to_rotation_matrix_top.sv
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_top: Euler angles to 3x3 rotation matrix
// Three CORDIC lanes feed the product stages that form Rx*Ry*Rz in Q1.14.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one item carries angle_x, angle_y, angle_z in degrees times 64.
//   out : one item carries r00..r22, signed Q1.14, for each input item.
//   From acceptance, an item passes the 31 CORDIC stage registers in each
//   lane, then the three product stages and the output register.
//   Throughput is one item per cycle when the receiver takes every item.
//   The whole pipeline advances as one: when the receiver stalls with a
//   result waiting, the pipeline holds and in.ready drops only while the
//   output register is full and not being taken.
//   Reset clears all valid bits; no item is in flight afterwards.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix_top import eamat_pkg::*; (
	input logic clk,
	input logic arst_n,
	eamat_if.sink   in_ch,
	eamat_if.source out_ch
);

	localparam int Depth = CordicSteps + 1 + 3;

	logic [Depth-1:0] vld_q;
	logic out_vld_q;
	matrix_t out_q;
	logic adv;
	cw_t s_x, c_x, s_y, c_y, s_z, c_z;
	matrix_t mat;
	angles_t ang;

	// advance whenever the output register is free or being drained
	assign adv = !out_vld_q || out_ch.ready;
	assign in_ch.ready = adv;
	assign ang = in_ch.data;

	eamat_sincos u_lx (.clk, .en(adv), .angle(ang.angle_x), .sin_v(s_x), .cos_v(c_x));
	eamat_sincos u_ly (.clk, .en(adv), .angle(ang.angle_y), .sin_v(s_y), .cos_v(c_y));
	eamat_sincos u_lz (.clk, .en(adv), .angle(ang.angle_z), .sin_v(s_z), .cos_v(c_z));

	eamat_merge u_merge (.clk, .en(adv), .sx(s_x), .cx(c_x), .sy(s_y), .cy(c_y),
		.sz(s_z), .cz(c_z), .mat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], in_ch.valid};
			out_vld_q <= vld_q[Depth-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_q <= mat;
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.data = out_q;

endmodule

FILE: design/eamat_checker.sv
// ----------------------------------------------------------------------------
// eamat_checker: port-level checks
// Watches the top level's channels for stall and pass-through behaviour and r22's range.
// ----------------------------------------------------------------------------
module eamat_checker import eamat_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input matrix_t out_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item not held under stall");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready not tied to output space");

	a_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.r22 <= 16'sd16384 && out_data.r22 >= -16'sd16384)
		else $error("entry beyond unit range");

endmodule

bind euler_angles_to_rotation_matrix_top eamat_checker u_chk (
	.clk, .arst_n, .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .out_data(out_ch.data));

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: Euler angles to rotation matrix
// Streams angle triples through the block, predicts each matrix with a
// bit-exact CORDIC and product model, and compares entries as they arrive.
// ----------------------------------------------------------------------------
module testbench;
	import eamat_pkg::*;

	localparam int FullUnits = 360 * 64;
	localparam int HalfUnits = 180 * 64;
	localparam int QuarterUnits = 90 * 64;
	localparam int Latency = 35;

	logic clk;
	logic arst_n;

	eamat_if #(.payload_t(angles_t)) in_ch (.clk(clk));
	eamat_if #(.payload_t(matrix_t)) out_ch (.clk(clk));

	euler_angles_to_rotation_matrix_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Arctangent of 2^-i in units of 2^-24 degree
	localparam longint AtanDeg [30] = '{
		754974720, 445687602, 235489088, 119537938, 60000934,
		30029717, 15018523, 7509720, 3754917, 1877466,
		938734, 469367, 234684, 117342, 58671,
		29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57,
		29, 14, 7, 4, 2
	};

	angles_t pending_angles[$];
	matrix_t expected_matrices[$];
	int sender_idle_pct;
	int receiver_idle_pct;
	int hold_off_cycles;
	bit stimulus_done;
	int mismatches;

	// Floor division by a power of two; >>> on longint already floors
	function automatic longint fshift(input longint v, input int n);
		return v >>> n;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint fixmul(input longint a, input longint b);
		return fshift(a * b + (64'sd1 <<< 29), 30);
	endfunction

	// Sine and cosine of one angle in Q2.30
	task automatic sine_cosine(input angle_t ang, output longint s, output longint c);
		longint a, x, y, z, dx, dy;
		bit flip;
		a = longint'(ang);
		flip = 0;
		a = a % FullUnits;
		if (a < 0) a += FullUnits;
		if (a > HalfUnits) a -= FullUnits;
		if (a > QuarterUnits) begin
			a = HalfUnits - a;
			flip = 1;
		end else if (a < -QuarterUnits) begin
			a = -HalfUnits - a;
			flip = 1;
		end
		z = a * (64'sd1 <<< 18);
		x = 652032874;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - AtanDeg[i];
			end else begin
				x = x + dx; y = y - dy; z = z + AtanDeg[i];
			end
		end
		x = clip(x, -(64'sd1 <<< 30), 64'sd1 <<< 30);
		y = clip(y, -(64'sd1 <<< 30), 64'sd1 <<< 30);
		c = flip ? -x : x;
		s = y;
	endtask

	function automatic entry_t round_entry(input longint v);
		longint r;
		r = fshift(v + (64'sd1 <<< 15), 16);
		r = clip(r, -16384, 16384);
		return entry_t'(r);
	endfunction

	task automatic predict_matrix(input angles_t a, output matrix_t m);
		longint sx, cx, sy, cy, sz, cz, sycz, sysz;
		sine_cosine(a.angle_x, sx, cx);
		sine_cosine(a.angle_y, sy, cy);
		sine_cosine(a.angle_z, sz, cz);
		sycz = fixmul(sy, cz);
		sysz = fixmul(sy, sz);
		m.r00 = round_entry(fixmul(cy, cz));
		m.r01 = round_entry(-fixmul(cy, sz));
		m.r02 = round_entry(-sy);
		m.r10 = round_entry(fixmul(cx, sz) - fixmul(sx, sycz));
		m.r11 = round_entry(fixmul(cx, cz) + fixmul(sx, sysz));
		m.r12 = round_entry(-fixmul(sx, cy));
		m.r20 = round_entry(fixmul(sx, sz) + fixmul(cx, sycz));
		m.r21 = round_entry(fixmul(sx, cz) - fixmul(cx, sysz));
		m.r22 = round_entry(fixmul(cx, cy));
	endtask

	function automatic angle_t random_angle();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return angle_t'(-23040 + $urandom_range(0, 3) * 5760);
		if (pick == 1) return angle_t'(16'($urandom)); // full 16-bit range
		if (pick == 2) return angle_t'(($urandom_range(0, 8) - 4) * 5760
			+ $urandom_range(0, 4) - 2);
		return angle_t'($urandom_range(0, 46080) - 23040);
	endfunction

	task automatic queue_triple(input int ax, input int ay, input int az);
		angles_t a;
		a.angle_x = angle_t'(ax);
		a.angle_y = angle_t'(ay);
		a.angle_z = angle_t'(az);
		pending_angles.push_back(a);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Driver: offer the head of the pending queue, drop it once taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 0;
			in_ch.data <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				matrix_t m;
				predict_matrix(in_ch.data, m);
				expected_matrices.push_back(m);
				void'(pending_angles.pop_front());
			end
			// Advance to the next item or hold the current one
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (pending_angles.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					in_ch.valid <= 1;
					in_ch.data <= pending_angles[0];
				end else begin
					in_ch.valid <= 0;
				end
			end
		end
	end

	// Monitor: compare each taken matrix with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_matrices.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected matrix %p", out_ch.data);
				end else begin
					matrix_t e;
					e = expected_matrices.pop_front();
					if (e !== out_ch.data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("matrix mismatch: expected %p got %p", e, out_ch.data);
					end
				end
			end
			// Hold off for a long stretch when asked, else stall at random
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				out_ch.ready <= 0;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int n;
		arst_n = 0;
		sender_idle_pct = 37;
		receiver_idle_pct = 74;
		hold_off_cycles = 0;
		mismatches = 0;
		stimulus_done = 0;
		// Directed: zeros, extremes, quadrant edges, sign bits, wrap past 360
		queue_triple(0, 0, 0);
		queue_triple(23040, -23040, 23040);
		queue_triple(-23040, 23040, -23040);
		queue_triple(5760, 0, 0);
		queue_triple(0, 5760, 0);
		queue_triple(0, 0, 5760);
		queue_triple(-5760, -5760, -5760);
		queue_triple(11520, 11520, 11520);
		queue_triple(-11520, 5761, -5761);
		queue_triple(5759, 11519, -11519);
		queue_triple(17280, -17280, 1);
		queue_triple(-1, 1, -1);
		queue_triple(32767, -32768, 32767);
		queue_triple(-32768, 32767, -32768);
		queue_triple(23041, -23041, 30000);
		queue_triple(2880, 2880, 2880);
		queue_triple(-2880, 8640, -14400);
		queue_triple(21600, -1440, 720);
		queue_triple(16'h5555 - 0, 16'h2AAA, -21846);
		repeat (10) @(posedge clk);
		arst_n <= 1;
		for (int phase = 0; phase < 3; phase++) begin
			n = (phase == 0) ? 300 : ((phase == 1) ? 300 : 330);
			for (int i = 0; i < n; i++)
				queue_triple(random_angle(), random_angle(), random_angle());
			if (phase == 1) hold_off_cycles = 200;
			while (pending_angles.size() > 0) @(posedge clk);
			sender_idle_pct = (phase == 0) ? 74 : 0;
			receiver_idle_pct = (phase == 0) ? 37 : 0;
		end
		stimulus_done = 1;
		while (expected_matrices.size() > 0) @(posedge clk);
		repeat (Latency + 10) @(posedge clk);
		if (mismatches == 0 && expected_matrices.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
